FILE: rtl/ews_pkg.sv
// Package for the earliest-finish worker select block.
// Field widths, register map, controller states and control structs.
// No dependencies.
package ews_pkg;

	localparam int NUM_WORKERS_DEF = 8;

	localparam int TIME_W  = 48;
	localparam int LEN_W   = 32;
	localparam int WIDX_W  = 3;
	localparam int MISS_W  = 4;
	localparam int FIN_W   = 50;
	localparam int WGT_W   = 8;
	localparam int PEN_W   = 32;
	localparam int PA_W    = WGT_W + FIN_W;
	localparam int PB_W    = PEN_W + MISS_W;
	localparam int SCORE_W = 59;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_FINISH_WEIGHT = 1'b0;
	localparam logic REG_PENALTY       = 1'b1;

	localparam logic [WGT_W-1:0] FINISH_WEIGHT_RST = 8'd1;
	localparam logic [PEN_W-1:0] PENALTY_RST       = 32'd100000;

	localparam logic OP_CANDIDATE = 1'b0;
	localparam logic OP_POP       = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MUL,
		ST_CMP,
		ST_READQ,
		ST_CHARGE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic upd;
		logic mul;
		logic cmp;
		logic rd_best;
		logic charge;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_pop;
		logic last;
	} stat_t;

	typedef struct packed {
		logic              opcode;
		logic [WIDX_W-1:0] worker_index;
		logic              can_run;
		logic              no_prediction;
		logic [LEN_W-1:0]  task_length;
		logic [MISS_W-1:0] missing_buffers;
		logic [TIME_W-1:0] current_time;
		logic              last_candidate;
	} item_t;

	typedef struct packed {
		logic [WIDX_W-1:0] chosen_worker;
		logic [LEN_W-1:0]  assigned_length;
		logic              forced_choice;
		logic              status;
	} result_t;

endpackage

FILE: rtl/ews_ifs.sv
// Valid/ready channel interfaces: task/pop requests in, choices out.
// Depends on ews_pkg for field widths.
interface ews_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [ews_pkg::WIDX_W-1:0] worker_index;
	logic                      can_run;
	logic                      no_prediction;
	logic [ews_pkg::LEN_W-1:0]  task_length;
	logic [ews_pkg::MISS_W-1:0] missing_buffers;
	logic [ews_pkg::TIME_W-1:0] current_time;
	logic                      last_candidate;

	modport source (
		output valid, opcode, worker_index, can_run, no_prediction,
		       task_length, missing_buffers, current_time, last_candidate,
		input  ready
	);
	modport sink (
		input  valid, opcode, worker_index, can_run, no_prediction,
		       task_length, missing_buffers, current_time, last_candidate,
		output ready
	);
endinterface

interface ews_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [ews_pkg::WIDX_W-1:0] chosen_worker;
	logic [ews_pkg::LEN_W-1:0]  assigned_length;
	logic                      forced_choice;
	logic                      status;

	modport source (
		output valid, chosen_worker, assigned_length, forced_choice, status,
		input  ready
	);
	modport sink (
		input  valid, chosen_worker, assigned_length, forced_choice, status,
		output ready
	);
endinterface

FILE: rtl/ews_cfg.sv
// APB-style register file: finish weight and missing-buffer penalty.
// Depends on ews_pkg.
module ews_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ews_pkg::PADDR_W-1:0] paddr,
	input  logic [ews_pkg::PDATA_W-1:0] pwdata,
	output logic [ews_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output logic [ews_pkg::WGT_W-1:0]   finish_weight,
	output logic [ews_pkg::PEN_W-1:0]   penalty_per_missing
);
	logic [ews_pkg::WGT_W-1:0] weight_q;
	logic [ews_pkg::PEN_W-1:0] penalty_q;
	logic                      wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q  <= ews_pkg::FINISH_WEIGHT_RST;
			penalty_q <= ews_pkg::PENALTY_RST;
		end else if (wr) begin
			case (paddr[2])
				ews_pkg::REG_FINISH_WEIGHT: weight_q <= pwdata[ews_pkg::WGT_W-1:0];
				ews_pkg::REG_PENALTY:       penalty_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ews_pkg::REG_FINISH_WEIGHT: prdata = {24'd0, weight_q};
			ews_pkg::REG_PENALTY:       prdata = penalty_q;
			default:                    prdata = '0;
		endcase
	end

	assign finish_weight       = weight_q;
	assign penalty_per_missing = penalty_q;
endmodule

FILE: rtl/ews_ctrl.sv
// Controller FSM: sequences load, update, multiply, compare, charge, emit.
// Depends on ews_pkg.
module ews_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  ews_pkg::stat_t  stat,
	output ews_pkg::cmd_t   cmd
);
	ews_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ews_pkg::ST_IDLE:   if (req_valid) state_nxt = ews_pkg::ST_UPDATE;
			ews_pkg::ST_UPDATE: state_nxt = stat.is_pop ? ews_pkg::ST_IDLE : ews_pkg::ST_MUL;
			ews_pkg::ST_MUL:    state_nxt = ews_pkg::ST_CMP;
			ews_pkg::ST_CMP:    state_nxt = stat.last ? ews_pkg::ST_READQ : ews_pkg::ST_IDLE;
			ews_pkg::ST_READQ:  state_nxt = ews_pkg::ST_CHARGE;
			ews_pkg::ST_CHARGE: state_nxt = ews_pkg::ST_DONE;
			ews_pkg::ST_DONE:   if (slot_free) state_nxt = ews_pkg::ST_IDLE;
			default:            state_nxt = ews_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ews_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ews_pkg::ST_UPDATE: cmd.upd     = 1'b1;
			ews_pkg::ST_MUL:    cmd.mul     = 1'b1;
			ews_pkg::ST_CMP:    cmd.cmp     = 1'b1;
			ews_pkg::ST_READQ:  cmd.rd_best = 1'b1;
			ews_pkg::ST_CHARGE: cmd.charge  = 1'b1;
			ews_pkg::ST_DONE:   cmd.emit    = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ews_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
endmodule

FILE: rtl/ews_dp.sv
// Datapath: per-worker start/queue stores, score multiply, running argmin,
// result register. Depends on ews_pkg; driven by ews_ctrl commands.
module ews_dp #(
	parameter int NUM_WORKERS = ews_pkg::NUM_WORKERS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ews_pkg::cmd_t             cmd,
	output ews_pkg::stat_t            stat,
	input  ews_pkg::item_t            item,
	input  logic [ews_pkg::WGT_W-1:0] finish_weight,
	input  logic [ews_pkg::PEN_W-1:0] penalty_per_missing,
	output ews_pkg::result_t          result
);
	localparam int IW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int TW = ews_pkg::TIME_W;
	localparam logic [TW-1:0] TMAX = '1;

	logic [TW-1:0] es_mem [NUM_WORKERS];
	logic [TW-1:0] ql_mem [NUM_WORKERS];
	logic [NUM_WORKERS-1:0] es_vld_q, ql_vld_q;
	logic [TW-1:0] es_rd_q, ql_rd_q;

	ews_pkg::item_t item_q;
	logic           in_range_q;
	logic           score_en_q;
	logic [ews_pkg::FIN_W-1:0]   finish_q;
	logic [ews_pkg::PA_W-1:0]    prod_a_s1;
	logic [ews_pkg::PB_W-1:0]    prod_b_s1;
	logic [ews_pkg::SCORE_W-1:0] best_score_q;
	logic [ews_pkg::WIDX_W-1:0]  best_worker_q;
	logic [ews_pkg::LEN_W-1:0]   best_len_q;
	logic                        have_best_q, forced_found_q;
	ews_pkg::result_t            result_q;

	logic [IW-1:0] in_addr, item_addr, best_addr, rd_addr, ql_wr_addr;
	logic          in_range;
	logic          is_pop, active;
	logic [TW-1:0] start, ql_pop, es_pop, es_wr_data, ql_wr_data, ql_charge;
	logic [TW:0]   es_pop_sum, charge_sum;
	logic          es_we, ql_we;
	logic [ews_pkg::SCORE_W-1:0] score;

	assign in_addr   = IW'(item.worker_index);
	assign item_addr = IW'(item_q.worker_index);
	assign best_addr = IW'(best_worker_q);
	assign rd_addr   = cmd.rd_best ? best_addr : in_addr;
	assign in_range  = 32'(item.worker_index) < 32'(NUM_WORKERS);

	assign is_pop = item_q.opcode == ews_pkg::OP_POP;
	assign active = !is_pop && in_range_q && !forced_found_q;

	assign start = (es_rd_q < item_q.current_time) ? item_q.current_time : es_rd_q;
	assign ql_pop = ({16'd0, item_q.task_length} >= ql_rd_q) ? '0
		: ql_rd_q - {16'd0, item_q.task_length};
	assign es_pop_sum = {1'b0, item_q.current_time} + {17'd0, item_q.task_length};
	assign es_pop = es_pop_sum[TW] ? TMAX : es_pop_sum[TW-1:0];
	assign charge_sum = {1'b0, ql_rd_q} + {17'd0, best_len_q};
	assign ql_charge = charge_sum[TW] ? TMAX : charge_sum[TW-1:0];

	assign es_we      = cmd.upd && in_range_q && (is_pop || !forced_found_q);
	assign es_wr_data = is_pop ? es_pop : start;
	assign ql_we      = (cmd.upd && in_range_q && is_pop)
		|| (cmd.charge && have_best_q && !forced_found_q);
	assign ql_wr_addr = cmd.charge ? best_addr : item_addr;
	assign ql_wr_data = cmd.charge ? ql_charge : ql_pop;

	assign score = ews_pkg::SCORE_W'(prod_a_s1) + ews_pkg::SCORE_W'(prod_b_s1);

	always_ff @(posedge clk) begin
		es_rd_q <= es_vld_q[rd_addr] ? es_mem[rd_addr] : '0;
		ql_rd_q <= ql_vld_q[rd_addr] ? ql_mem[rd_addr] : '0;
		if (es_we)
			es_mem[item_addr] <= es_wr_data;
		if (ql_we)
			ql_mem[ql_wr_addr] <= ql_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_vld_q <= '0;
			ql_vld_q <= '0;
		end else begin
			if (es_we)
				es_vld_q[item_addr] <= 1'b1;
			if (ql_we)
				ql_vld_q[ql_wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q     <= item;
			in_range_q <= in_range;
		end
		if (cmd.upd) begin
			finish_q <= {2'd0, start} + {2'd0, ql_rd_q} + {18'd0, item_q.task_length};
			score_en_q <= active && item_q.can_run && !item_q.no_prediction;
		end
		if (cmd.mul) begin
			prod_a_s1 <= finish_weight * finish_q;
			prod_b_s1 <= penalty_per_missing * item_q.missing_buffers;
		end
		if (cmd.emit) begin
			if (forced_found_q)
				result_q <= '{best_worker_q, '0, 1'b1, 1'b0};
			else if (have_best_q)
				result_q <= '{best_worker_q, best_len_q, 1'b0, 1'b0};
			else
				result_q <= '{'0, '0, 1'b0, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q    <= 1'b0;
			forced_found_q <= 1'b0;
			best_score_q   <= '1;
			best_worker_q  <= '0;
			best_len_q     <= '0;
		end else if (cmd.emit) begin
			have_best_q    <= 1'b0;
			forced_found_q <= 1'b0;
			best_score_q   <= '1;
			best_worker_q  <= '0;
			best_len_q     <= '0;
		end else if (cmd.upd && active && item_q.can_run && item_q.no_prediction) begin
			forced_found_q <= 1'b1;
			best_worker_q  <= item_q.worker_index;
		end else if (cmd.cmp && score_en_q && (!have_best_q || score < best_score_q)) begin
			have_best_q   <= 1'b1;
			best_score_q  <= score;
			best_worker_q <= item_q.worker_index;
			best_len_q    <= item_q.task_length;
		end
	end

	assign stat.is_pop = is_pop;
	assign stat.last   = item_q.last_candidate;
	assign result      = result_q;
endmodule

FILE: rtl/earliest_finish_worker_select.sv
// Earliest-finish worker select, top level.
// Only a last candidate yields a result; pops and other candidates give none.
// Throughput: one request at a time through the controller sequence
// (read store, update, multiply, compare, then read/charge queue on last).
// Async active-low reset: stores read as zero; controller, config and best-choice registers take reset values.
module earliest_finish_worker_select #(
	parameter int NUM_WORKERS = ews_pkg::NUM_WORKERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ews_pkg::PADDR_W-1:0] paddr,
	input  logic [ews_pkg::PDATA_W-1:0] pwdata,
	output logic [ews_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	ews_req_if.sink                     req,
	ews_rsp_if.source                   rsp
);
	logic [ews_pkg::WGT_W-1:0] finish_weight;
	logic [ews_pkg::PEN_W-1:0] penalty_per_missing;
	ews_pkg::cmd_t             cmd;
	ews_pkg::stat_t            stat;
	ews_pkg::item_t            item;
	ews_pkg::result_t          result;

	assign item = '{req.opcode, req.worker_index, req.can_run, req.no_prediction,
		req.task_length, req.missing_buffers, req.current_time, req.last_candidate};

	ews_cfg u_cfg (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.finish_weight       (finish_weight),
		.penalty_per_missing (penalty_per_missing)
	);

	ews_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ews_dp #(
		.NUM_WORKERS (NUM_WORKERS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.item                (item),
		.finish_weight       (finish_weight),
		.penalty_per_missing (penalty_per_missing),
		.result              (result)
	);

	assign rsp.chosen_worker   = result.chosen_worker;
	assign rsp.assigned_length = result.assigned_length;
	assign rsp.forced_choice   = result.forced_choice;
	assign rsp.status          = result.status;
endmodule
